// File: hdl/segment_allocator_fit_strategies_core_macros.svh
// Assertion macros shared by the segment allocator RTL.
`ifndef SEGMENT_ALLOCATOR_FIT_STRATEGIES_CORE_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIT_STRATEGIES_CORE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define SAFS_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define SAFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/safs_pkg.sv
// Types, constants and codes of the segment allocator.
`default_nettype none
package safs_pkg;
	localparam int BLOCK_BYTES  = 1;
	localparam int FREE_ENTRIES = 16;
	localparam int USED_ENTRIES = 16;
	localparam int IDX_W        = 16;
	localparam int MAX_ENTRIES  = (FREE_ENTRIES > USED_ENTRIES) ? FREE_ENTRIES : USED_ENTRIES;
	localparam int CNT_W        = $clog2(MAX_ENTRIES + 1);
	localparam int FA_W         = $clog2(FREE_ENTRIES);
	localparam int UA_W         = $clog2(USED_ENTRIES);
	localparam int ENTRY_W      = 2 * IDX_W;
	localparam int CFG_IDX_W    = 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_ALT   = 2'd3
	} fit_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NOFIT    = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_ZERO     = 3'd4
	} status_t;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL = 1'd1;
endpackage
`default_nettype wire

// File: hdl/safs_if.sv
// Handshake channels of the segment allocator: request, response and configuration.
`default_nettype none
interface safs_req_if import safs_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] request_bytes;
	logic [15:0] free_index;
	modport source (output valid, action, request_bytes, free_index, input ready);
	modport sink (input valid, action, request_bytes, free_index, output ready);
endinterface

interface safs_rsp_if import safs_pkg::*; ();
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [15:0] start_index;
	logic [15:0] granted_blocks;
	modport source (output valid, status, start_index, granted_blocks, input ready);
	modport sink (input valid, status, start_index, granted_blocks, output ready);
endinterface

interface safs_cfg_if import safs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [15:0]          data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/safs_ram.sv
// Generic single-write, single-read RAM with a registered read.
`default_nettype none
module safs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/segment_allocator_fit_strategies_core.sv
// Segment allocator top level: free and used segment tables with first, best and worst fit.
// The free and used segment lists each live in a small RAM with a registered read; new
// entries are written to the front slot. A request is taken only while the sequencer is
// idle. Allocate scans the free list one entry per cycle and then opens the front slot of
// the used list by moving each entry back one place. An exact fit also closes the gap in
// the free list by moving each entry behind the removed one forward. Free scans the used
// list the same way and reorders both lists alike. Zero-size and no-op requests skip the
// scan, and reinitialize rewrites the initial free segment. A stalled response holds the
// sequencer in its output state. After reset the block writes the initial free segment in
// its boot state before it accepts a request. The result sits in an output register, so
// the next request can start while a response waits.
`default_nettype none
`include "segment_allocator_fit_strategies_core_macros.svh"
module segment_allocator_fit_strategies_core import safs_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	safs_req_if.sink   req,
	safs_rsp_if.source rsp,
	safs_cfg_if.sink   cfg
);
	typedef enum logic [10:0] {
		S_BOOT     = 11'b000_0000_0001,
		S_IDLE     = 11'b000_0000_0010,
		S_INIT     = 11'b000_0000_0100,
		S_SCAN     = 11'b000_0000_1000,
		S_DECIDE   = 11'b000_0001_0000,
		S_CLOSE_RD = 11'b000_0010_0000,
		S_CLOSE_WR = 11'b000_0100_0000,
		S_OPEN_RD  = 11'b000_1000_0000,
		S_OPEN_WR  = 11'b001_0000_0000,
		S_FRONT    = 11'b010_0000_0000,
		S_OUT      = 11'b100_0000_0000
	} state_t;

	state_t  state_q;
	fit_t    strat_q;
	idx_t    total_q;
	cnt_t    fcnt_q, ucnt_q;
	logic    op_alloc_q;
	idx_t    need_q, key_q;
	cnt_t    ptr_q, idx_s1, pick_q, k_q;
	logic    v_s1, found_q;
	idx_t    pick_start_q, pick_len_q;
	status_t res_status_q;
	idx_t    res_start_q, res_len_q;
	logic    out_v_q;
	status_t out_status_q;
	idx_t    out_start_q, out_len_q;

	logic [ENTRY_W-1:0] f_rdata, u_rdata, f_wdata, u_wdata;
	logic               f_we, u_we;
	cnt_t               rd_addr, f_waddr_c, u_waddr_c;
	logic [ENTRY_W-1:0] scan_rdata, close_rdata, open_rdata;
	idx_t               scan_start, scan_len;
	cnt_t               scan_cnt, close_cnt, open_cnt;
	logic               better;
	logic [IDX_W:0]     need_sum;
	idx_t               need_c;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_q <= FIT_FIRST;
			total_q <= IDX_W'(100);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_FIT:   strat_q <= fit_t'(cfg.data[1:0]);
				CFG_TOTAL: total_q <= cfg.data;
				default:   ;
			endcase
		end
	end

	// Request rounding to whole blocks.
	assign need_sum = {1'b0, req.request_bytes} + (IDX_W+1)'(BLOCK_BYTES - 1);
	assign need_c   = IDX_W'(need_sum / BLOCK_BYTES);

	// Table selection: allocate scans and closes the free list, free the used list.
	assign scan_rdata  = op_alloc_q ? f_rdata : u_rdata;
	assign close_rdata = scan_rdata;
	assign open_rdata  = op_alloc_q ? u_rdata : f_rdata;
	assign scan_cnt    = op_alloc_q ? fcnt_q : ucnt_q;
	assign close_cnt   = scan_cnt;
	assign open_cnt    = op_alloc_q ? ucnt_q : fcnt_q;
	assign scan_start  = scan_rdata[ENTRY_W-1:IDX_W];
	assign scan_len    = scan_rdata[IDX_W-1:0];

	// Candidate test during the scan.
	always_comb begin
		better = 1'b0;
		if (op_alloc_q) begin
			if (scan_len >= need_q) begin
				priority if (!found_q) better = 1'b1;
				else if (strat_q == FIT_BEST) better = scan_len < pick_len_q;
				else if (strat_q == FIT_WORST) better = scan_len > pick_len_q;
				else better = 1'b0;
			end
		end else begin
			better = !found_q && (scan_start == key_q);
		end
	end

	// Read address for the scan and for list moves.
	always_comb begin
		unique case (state_q)
			S_SCAN:     rd_addr = ptr_q;
			S_CLOSE_RD: rd_addr = CNT_W'(k_q + 1'b1);
			S_OPEN_RD:  rd_addr = CNT_W'(k_q - 1'b1);
			default:    rd_addr = '0;
		endcase
	end

	// Write ports of both tables.
	always_comb begin
		f_we = 1'b0; f_waddr_c = '0; f_wdata = '0;
		u_we = 1'b0; u_waddr_c = '0; u_wdata = '0;
		unique case (state_q)
			S_BOOT, S_INIT: begin
				f_we    = 1'b1;
				f_wdata = {IDX_W'(0), total_q};
			end
			S_DECIDE: begin
				f_we      = op_alloc_q && found_q && (ucnt_q < CNT_W'(USED_ENTRIES))
				            && (pick_len_q != need_q);
				f_waddr_c = pick_q;
				f_wdata   = {IDX_W'(pick_start_q + need_q), IDX_W'(pick_len_q - need_q)};
			end
			S_CLOSE_WR: begin
				if (op_alloc_q) begin
					f_we = 1'b1; f_waddr_c = k_q; f_wdata = close_rdata;
				end else begin
					u_we = 1'b1; u_waddr_c = k_q; u_wdata = close_rdata;
				end
			end
			S_OPEN_WR: begin
				if (op_alloc_q) begin
					u_we = 1'b1; u_waddr_c = k_q; u_wdata = open_rdata;
				end else begin
					f_we = 1'b1; f_waddr_c = k_q; f_wdata = open_rdata;
				end
			end
			S_FRONT: begin
				if (op_alloc_q) begin
					u_we = 1'b1; u_wdata = {res_start_q, res_len_q};
				end else begin
					f_we = 1'b1; f_wdata = {res_start_q, res_len_q};
				end
			end
			default: ;
		endcase
	end

	safs_ram #(.WIDTH(ENTRY_W), .DEPTH(FREE_ENTRIES)) u_free_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (f_waddr_c[FA_W-1:0]),
		.wdata (f_wdata),
		.raddr (rd_addr[FA_W-1:0]),
		.rdata (f_rdata)
	);

	safs_ram #(.WIDTH(ENTRY_W), .DEPTH(USED_ENTRIES)) u_used_ram (
		.clk   (clk),
		.we    (u_we),
		.waddr (u_waddr_c[UA_W-1:0]),
		.wdata (u_wdata),
		.raddr (rd_addr[UA_W-1:0]),
		.rdata (u_rdata)
	);

	assign req.ready = (state_q == S_IDLE);

	// Sequencer: scan, decide, move entries, write the front slot, report.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_BOOT;
			fcnt_q     <= CNT_W'(1);
			ucnt_q     <= '0;
			op_alloc_q <= 1'b0;
			found_q    <= 1'b0;
			v_s1       <= 1'b0;
			ptr_q      <= '0;
			k_q        <= '0;
			out_v_q    <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_BOOT: state_q <= S_IDLE;
				S_IDLE: begin
					if (req.valid) begin
						res_status_q <= ST_OK;
						res_start_q  <= '0;
						res_len_q    <= '0;
						found_q      <= 1'b0;
						v_s1         <= 1'b0;
						ptr_q        <= '0;
						need_q       <= need_c;
						key_q        <= req.free_index;
						unique case (action_t'(req.action))
							ACT_ALLOC: begin
								op_alloc_q <= 1'b1;
								if (req.request_bytes == '0) begin
									res_status_q <= ST_ZERO;
									state_q      <= S_OUT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							ACT_FREE: begin
								op_alloc_q <= 1'b0;
								state_q    <= S_SCAN;
							end
							ACT_INIT: begin
								fcnt_q  <= (total_q != '0) ? CNT_W'(1) : '0;
								ucnt_q  <= '0;
								state_q <= S_INIT;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_INIT: state_q <= S_OUT;
				S_SCAN: begin
					if (ptr_q < scan_cnt) begin
						v_s1   <= 1'b1;
						idx_s1 <= ptr_q;
						ptr_q  <= CNT_W'(ptr_q + 1'b1);
					end else begin
						v_s1 <= 1'b0;
					end
					if (v_s1 && better) begin
						found_q      <= 1'b1;
						pick_q       <= idx_s1;
						pick_start_q <= scan_start;
						pick_len_q   <= scan_len;
					end
					if (ptr_q == scan_cnt && !v_s1) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					k_q <= pick_q;
					if (!found_q) begin
						res_status_q <= op_alloc_q ? ST_NOFIT : ST_NOTFOUND;
						state_q      <= S_OUT;
					end else if (op_alloc_q && ucnt_q >= CNT_W'(USED_ENTRIES)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_OUT;
					end else if (!op_alloc_q && fcnt_q >= CNT_W'(FREE_ENTRIES)) begin
						res_status_q <= ST_FULL;
						state_q      <= S_OUT;
					end else begin
						res_start_q <= pick_start_q;
						res_len_q   <= op_alloc_q ? need_q : pick_len_q;
						if (op_alloc_q && pick_len_q != need_q) begin
							k_q     <= ucnt_q;
							state_q <= S_OPEN_RD;
						end else begin
							state_q <= S_CLOSE_RD;
						end
					end
				end
				S_CLOSE_RD: begin
					if (CNT_W'(k_q + 1'b1) < close_cnt) begin
						state_q <= S_CLOSE_WR;
					end else begin
						if (op_alloc_q) begin
							fcnt_q <= CNT_W'(fcnt_q - 1'b1);
						end else begin
							ucnt_q <= CNT_W'(ucnt_q - 1'b1);
						end
						k_q     <= open_cnt;
						state_q <= S_OPEN_RD;
					end
				end
				S_CLOSE_WR: begin
					k_q     <= CNT_W'(k_q + 1'b1);
					state_q <= S_CLOSE_RD;
				end
				S_OPEN_RD: begin
					state_q <= (k_q != '0) ? S_OPEN_WR : S_FRONT;
				end
				S_OPEN_WR: begin
					k_q     <= CNT_W'(k_q - 1'b1);
					state_q <= S_OPEN_RD;
				end
				S_FRONT: begin
					if (op_alloc_q) begin
						ucnt_q <= CNT_W'(ucnt_q + 1'b1);
					end else begin
						fcnt_q <= CNT_W'(fcnt_q + 1'b1);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_v_q || rsp.ready) begin
						out_v_q      <= 1'b1;
						out_status_q <= res_status_q;
						out_start_q  <= res_start_q;
						out_len_q    <= res_len_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.status         = out_status_q;
	assign rsp.start_index    = out_start_q;
	assign rsp.granted_blocks = out_len_q;

	`SAFS_ASSERT_ALWAYS(a_fcnt_range, clk, arst_n, fcnt_q <= CNT_W'(FREE_ENTRIES), "fcnt high")
	`SAFS_ASSERT_ALWAYS(a_ucnt_range, clk, arst_n, ucnt_q <= CNT_W'(USED_ENTRIES), "ucnt high")
	`SAFS_ASSERT_NEXT(a_req_busy, clk, arst_n, req.valid && req.ready, state_q != S_IDLE, "idle")
	`SAFS_ASSERT_NEXT(a_out_load, clk, arst_n, state_q != S_OUT && !out_v_q, !out_v_q, "stray")
endmodule
`default_nettype wire
